>>> rtl/core/hpp_pkg.sv
// Haptic pulse pattern player: shared types, constants and the pattern table.
// No dependencies; used by the interfaces and the top level.
`default_nettype none

package hpp_pkg;

    localparam int SLOTS         = 4;
    localparam int MAX_PULSES    = 4;
    localparam int PATTERN_COUNT = 9;
    localparam int MS_W          = 9;
    localparam int IDX_W         = 2;
    localparam int CNT_W         = 3;
    localparam int CODE_W        = 4;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_PLAY = 1'b1;

    typedef struct packed {
        logic [MS_W-1:0] on_ms;
        logic [MS_W-1:0] pause_ms;
    } pulse_t;

    // Pulses stored for a code; invalid codes hold none.
    function automatic logic [CNT_W-1:0] pulse_count(input logic [CODE_W-1:0] code);
        logic [CNT_W-1:0] n;
        unique case (code)
            4'd1:    n = 3'd1;
            4'd2:    n = 3'd2;
            4'd3:    n = 3'd3;
            4'd4:    n = 3'd1;
            4'd5:    n = 3'd4;
            4'd6:    n = 3'd3;
            4'd7:    n = 3'd3;
            4'd8:    n = 3'd2;
            4'd9:    n = 3'd2;
            default: n = 3'd0;
        endcase
        return n;
    endfunction

    // Pulses actually played, capped by MAX_PULSES and the slot count.
    function automatic logic [CNT_W-1:0] used_pulses(input logic [CODE_W-1:0] code);
        logic [CNT_W-1:0] n;
        n = pulse_count(code);
        if (MAX_PULSES < int'(n))
            n = CNT_W'(MAX_PULSES);
        if (SLOTS < int'(n))
            n = CNT_W'(SLOTS);
        return n;
    endfunction

    function automatic pulse_t pulse_lookup(input logic [CODE_W-1:0] code,
                                            input logic [IDX_W-1:0]  idx);
        pulse_t p;
        p = '{on_ms: '0, pause_ms: '0};
        unique case (code)
            4'd1: if (idx == 2'd0) p = '{on_ms: 9'd50, pause_ms: 9'd0};
            4'd2:
            begin
                if (idx == 2'd0) p = '{on_ms: 9'd50, pause_ms: 9'd200};
                if (idx == 2'd1) p = '{on_ms: 9'd50, pause_ms: 9'd0};
            end
            4'd3:
            begin
                if (idx == 2'd0) p = '{on_ms: 9'd10, pause_ms: 9'd50};
                if (idx == 2'd1) p = '{on_ms: 9'd20, pause_ms: 9'd50};
                if (idx == 2'd2) p = '{on_ms: 9'd30, pause_ms: 9'd0};
            end
            4'd4: if (idx == 2'd0) p = '{on_ms: 9'd500, pause_ms: 9'd0};
            4'd5:
            begin
                if (idx == 2'd0) p = '{on_ms: 9'd150, pause_ms: 9'd0};
                else             p = '{on_ms: 9'd100, pause_ms: 9'd0};
            end
            4'd6:
            begin
                if (idx == 2'd0 || idx == 2'd1) p = '{on_ms: 9'd100, pause_ms: 9'd0};
                if (idx == 2'd2)                p = '{on_ms: 9'd150, pause_ms: 9'd0};
            end
            4'd7:
            begin
                if (idx == 2'd0)                p = '{on_ms: 9'd150, pause_ms: 9'd0};
                if (idx == 2'd1 || idx == 2'd2) p = '{on_ms: 9'd100, pause_ms: 9'd0};
            end
            4'd8: if (idx == 2'd0 || idx == 2'd1) p = '{on_ms: 9'd150, pause_ms: 9'd0};
            4'd9: if (idx == 2'd0 || idx == 2'd1) p = '{on_ms: 9'd100, pause_ms: 9'd0};
            default: p = '{on_ms: '0, pause_ms: '0};
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/hpp_cmd_if.sv
// Request channel of the haptic pulse pattern player: command and pattern code.
// Depends on hpp_pkg.
`default_nettype none

interface hpp_cmd_if
    import hpp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              command;
    logic [CODE_W-1:0] pattern;

    modport source (output valid, command, pattern, input ready);
    modport sink   (input valid, command, pattern, output ready);
endinterface

`default_nettype wire

>>> rtl/core/hpp_rsp_if.sv
// Result channel of the haptic pulse pattern player: drive level and busy flag.
// Depends on hpp_pkg.
`default_nettype none

interface hpp_rsp_if
    import hpp_pkg::*;
();
    logic valid;
    logic ready;
    logic motor_on;
    logic busy_res;

    modport source (output valid, motor_on, busy_res, input ready);
    modport sink   (input valid, motor_on, busy_res, output ready);
endinterface

`default_nettype wire

>>> rtl/core/haptic_pulse_pattern_player.sv
// Haptic pulse pattern player top level: player state, pattern table lookup, result register.
// Depends on hpp_pkg, hpp_cmd_if and hpp_rsp_if.
//
//   channel  dir  payload             meaning
//   cmd      in   command, pattern    1 ms tick or play request
//   rsp      out  motor_on, busy_res  drive level and busy flag after each request
//
// One request per cycle while cmd.ready is high; each yields its result in the cycle after acceptance.
// The state update and table lookup sit between the player registers and the result register.
// cmd.ready is high while the result register is empty or being drained.
// Reset clears the player to idle and empties the result register.
`default_nettype none

module haptic_pulse_pattern_player
    import hpp_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    hpp_cmd_if.sink    cmd,
    hpp_rsp_if.source  rsp
);

    logic              playing_reg,   playing_next;
    logic [CODE_W-1:0] pattern_reg,   pattern_next;
    logic [IDX_W-1:0]  index_reg,     index_next;
    logic              in_pause_reg,  in_pause_next;
    logic [MS_W-1:0]   remain_reg,    remain_next;

    logic              rsp_valid_reg;
    logic              motor_on_reg;
    logic              busy_reg;

    logic              accept;
    logic [MS_W-1:0]   remain_dec;
    logic [IDX_W-1:0]  index_inc;
    pulse_t            cur_pulse;
    pulse_t            nxt_pulse;
    pulse_t            start_pulse;

    assign cmd.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = cmd.valid && cmd.ready;

    assign index_inc   = index_reg + 2'd1;
    assign cur_pulse   = pulse_lookup(pattern_reg, index_reg);
    assign nxt_pulse   = pulse_lookup(pattern_reg, index_inc);
    assign start_pulse = pulse_lookup(cmd.pattern, '0);
    assign remain_dec  = (remain_reg == '0) ? '0 : remain_reg - 9'd1;

    always_comb
    begin
        playing_next  = playing_reg;
        pattern_next  = pattern_reg;
        index_next    = index_reg;
        in_pause_next = in_pause_reg;
        remain_next   = remain_reg;
        if (cmd.command == CMD_PLAY)
        begin
            if (!playing_reg && used_pulses(cmd.pattern) != '0)
            begin
                playing_next  = 1'b1;
                pattern_next  = cmd.pattern;
                index_next    = '0;
                in_pause_next = 1'b0;
                remain_next   = start_pulse.on_ms;
            end
        end
        else if (playing_reg)
        begin
            remain_next = remain_dec;
            if (remain_dec == '0)
            begin
                priority if (!in_pause_reg && cur_pulse.pause_ms != '0)
                begin
                    in_pause_next = 1'b1;
                    remain_next   = cur_pulse.pause_ms;
                end
                else if ({1'b0, index_reg} + 3'd1 < used_pulses(pattern_reg))
                begin
                    index_next    = index_inc;
                    in_pause_next = 1'b0;
                    remain_next   = nxt_pulse.on_ms;
                end
                else
                begin
                    playing_next  = 1'b0;
                    pattern_next  = '0;
                    index_next    = '0;
                    in_pause_next = 1'b0;
                    remain_next   = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            playing_reg   <= 1'b0;
            pattern_reg   <= '0;
            index_reg     <= '0;
            in_pause_reg  <= 1'b0;
            remain_reg    <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                playing_reg  <= playing_next;
                pattern_reg  <= pattern_next;
                index_reg    <= index_next;
                in_pause_reg <= in_pause_next;
                remain_reg   <= remain_next;
            end
            if (accept)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            motor_on_reg <= playing_next && !in_pause_next;
            busy_reg     <= playing_next;
        end
    end

    assign rsp.valid    = rsp_valid_reg;
    assign rsp.motor_on = motor_on_reg;
    assign rsp.busy_res = busy_reg;

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
// Testbench for haptic_pulse_pattern_player: drives play and tick requests with random
// idling and back-pressure, predicts every result and checks it. Uses hpp_pkg,
// hpp_cmd_if and hpp_rsp_if.
`default_nettype none

module tb_top;
    import hpp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1900;
    localparam int HOLD_CYCLES  = 60;
    localparam int DRAIN_CYCLES = 20;

    localparam int ON_MS [1:9][0:3] = '{
        '{50, 0, 0, 0}, '{50, 50, 0, 0}, '{10, 20, 30, 0}, '{500, 0, 0, 0},
        '{150, 100, 100, 100}, '{100, 100, 150, 0}, '{150, 100, 100, 0},
        '{150, 150, 0, 0}, '{100, 100, 0, 0}
    };
    localparam int PAUSE_MS [1:9][0:3] = '{
        '{0, 0, 0, 0}, '{200, 0, 0, 0}, '{50, 50, 0, 0}, '{0, 0, 0, 0},
        '{0, 0, 0, 0}, '{0, 0, 0, 0}, '{0, 0, 0, 0}, '{0, 0, 0, 0}, '{0, 0, 0, 0}
    };
    localparam int PULSE_COUNT [1:9] = '{1, 2, 3, 1, 4, 3, 3, 2, 2};

    typedef struct packed {
        logic              playing;
        logic [CODE_W-1:0] code;
        logic [IDX_W-1:0]  step;
        logic              resting;
        logic [MS_W-1:0]   left_ms;
    } player_t;

    typedef struct packed {
        logic motor_on;
        logic busy_res;
    } drive_t;

    logic clk;
    logic rst_n;

    hpp_cmd_if cmd();
    hpp_rsp_if rsp();

    haptic_pulse_pattern_player dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .rsp   (rsp)
    );

    player_t     plr;
    drive_t      pending_drive[$];
    logic [9:0]  played_mask;
    int          sent_items;
    int          error_count;
    bit          src_gaps;
    bit          sink_gaps;
    bit          hold_request;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #30ms;
        $display("FAIL");
        $finish;
    end

    function automatic int idle_span();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic int pulses_used(input logic [CODE_W-1:0] code);
        int n;
        if (code < 1 || code > PATTERN_COUNT)
            return 0;
        n = PULSE_COUNT[code];
        if (n > MAX_PULSES)
            n = MAX_PULSES;
        if (n > SLOTS)
            n = SLOTS;
        return n;
    endfunction

    // Phase ran out: go to the pause, the next pulse, or idle.
    function automatic void close_phase();
        int rest;
        rest = PAUSE_MS[plr.code][plr.step];
        if (!plr.resting && rest > 0)
        begin
            plr.resting = 1'b1;
            plr.left_ms = MS_W'(rest);
        end
        else if (int'(plr.step) + 1 < pulses_used(plr.code))
        begin
            plr.step    = plr.step + 1'b1;
            plr.resting = 1'b0;
            plr.left_ms = MS_W'(ON_MS[plr.code][plr.step]);
        end
        else
            plr = '0;
    endfunction

    function automatic drive_t advance_player(input logic command,
                                              input logic [CODE_W-1:0] code);
        drive_t d;
        if (command == CMD_PLAY)
        begin
            if (!plr.playing && pulses_used(code) > 0)
            begin
                plr.playing = 1'b1;
                plr.code    = code;
                plr.step    = '0;
                plr.resting = 1'b0;
                plr.left_ms = MS_W'(ON_MS[code][0]);
                played_mask[code] = 1'b1;
            end
        end
        else if (plr.playing)
        begin
            if (plr.left_ms > 0)
                plr.left_ms = plr.left_ms - 1'b1;
            if (plr.left_ms == 0)
                close_phase();
        end
        d.motor_on = plr.playing && !plr.resting;
        d.busy_res = plr.playing;
        return d;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    always @(posedge clk)
    begin : scoreboard
        drive_t want;
        if (rst_n)
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (pending_drive.size() == 0)
                    report_mismatch("result with no request pending", 1, 0);
                else
                begin
                    want = pending_drive.pop_front();
                    if (rsp.motor_on !== want.motor_on)
                        report_mismatch("motor_on", rsp.motor_on, want.motor_on);
                    if (rsp.busy_res !== want.busy_res)
                        report_mismatch("busy_res", rsp.busy_res, want.busy_res);
                end
            end
            if (cmd.valid && cmd.ready)
                pending_drive.push_back(advance_player(cmd.command, cmd.pattern));
        end
    end

    // Result side: random stalls, plus one long hold when asked.
    initial
    begin : sink_ready
        int span;
        rsp.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            span = sink_gaps && $urandom_range(0, 3) == 0 ? idle_span() : 0;
            if (hold_request)
            begin
                rsp.ready <= 1'b0;
                for (int i = 0; i < HOLD_CYCLES; i++)
                    @(negedge clk);
                hold_request = 1'b0;
                rsp.ready <= 1'b1;
            end
            else if (span > 0)
            begin
                rsp.ready <= 1'b0;
                repeat (span) @(negedge clk);
                rsp.ready <= 1'b1;
            end
            else
                rsp.ready <= 1'b1;
        end
    end

    task automatic send_request(input logic command, input logic [CODE_W-1:0] code);
        int gap;
        gap = src_gaps ? idle_span() : 0;
        sent_items++;
        if (gap > 0)
        begin
            cmd.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd.valid   <= 1'b1;
        cmd.command <= command;
        cmd.pattern <= code;
        do
            @(posedge clk);
        while (!cmd.ready);
        @(negedge clk);
    endtask

    task automatic tick_until_idle(input bit noisy);
        while (plr.playing)
        begin
            if (noisy && $urandom_range(0, 19) == 0)
                send_request(CMD_PLAY, CODE_W'($urandom_range(0, 15)));
            else
                send_request(CMD_TICK, CODE_W'($urandom_range(0, 15)));
        end
    endtask

    task automatic test_idle_requests();
        send_request(CMD_TICK, 4'd15);
        send_request(CMD_TICK, 4'd0);
        send_request(CMD_PLAY, 4'd0);
        for (int c = 10; c <= 15; c++)
            send_request(CMD_PLAY, CODE_W'(c));
        send_request(CMD_TICK, 4'd5);
    endtask

    task automatic test_busy_drop();
        send_request(CMD_PLAY, 4'd3);
        repeat (3) send_request(CMD_TICK, 4'd0);
        send_request(CMD_PLAY, 4'd15);
        send_request(CMD_PLAY, 4'd1);
        send_request(CMD_PLAY, 4'd9);
        send_request(CMD_TICK, 4'd9);
        send_request(CMD_PLAY, 4'd3);
    endtask

    task automatic test_backpressure();
        src_gaps     = 1'b0;
        hold_request = 1'b1;
        repeat (16) send_request(CMD_TICK, CODE_W'($urandom_range(0, 15)));
        src_gaps = 1'b1;
    endtask

    task automatic test_random_patterns();
        logic [CODE_W-1:0] code;
        int n;
        while (sent_items < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 7) == 0)
                src_gaps = !src_gaps;
            if ($urandom_range(0, 7) == 0)
                sink_gaps = !sink_gaps;
            if ($urandom_range(0, 4) == 0)
            begin
                n = $urandom_range(1, 12);
                repeat (n) send_request(1'($urandom_range(0, 1)),
                                        CODE_W'($urandom_range(0, 15)));
            end
            else
            begin
                tick_until_idle(1'b0);
                code = CODE_W'($urandom_range(1, 9));
                for (int i = 0; i < 9 && played_mask[code]; i++)
                    code = code == 4'd9 ? 4'd1 : code + 1'b1;
                send_request(CMD_PLAY, code);
                tick_until_idle(1'b1);
            end
        end
    endtask

    initial
    begin
        cmd.valid    = 1'b0;
        cmd.command  = CMD_TICK;
        cmd.pattern  = '0;
        rst_n        = 1'b0;
        plr          = '0;
        played_mask  = '0;
        sent_items   = 0;
        error_count  = 0;
        src_gaps     = 1'b1;
        sink_gaps    = 1'b1;
        hold_request = 1'b0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_idle_requests();
        test_busy_drop();
        test_backpressure();
        test_random_patterns();

        cmd.valid <= 1'b0;
        while (pending_drive.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
